### rtl/afld_pkg.sv
`timescale 1ns / 1ps

package afld_pkg;

    // opcodes that open a frame
    localparam logic [7:0] OP_CHALLENGE = 8'h00;
    localparam logic [7:0] OP_PROOF     = 8'h01;
    localparam logic [7:0] OP_REALM     = 8'h10;

    // frame kinds as reported on the result side
    localparam logic [1:0] KIND_CHALLENGE = 2'd0;
    localparam logic [1:0] KIND_PROOF     = 2'd1;
    localparam logic [1:0] KIND_REALM     = 2'd2;

    // configuration register indexes
    localparam logic CFG_PROOF_SUCCESS_LEN = 1'b0;
    localparam logic CFG_PROOF_FAILURE_LEN = 1'b1;

    localparam logic [5:0] PROOF_SUCCESS_LEN_RST = 6'd32;
    localparam logic [2:0] PROOF_FAILURE_LEN_RST = 3'd2;
    localparam logic [5:0] PROOF_MIN_LEN         = 6'd2;

    // challenge layout
    localparam logic [16:0] CHAL_STATUS_OFF = 17'd2;
    localparam logic [16:0] CHAL_GLEN_OFF   = 17'd35;
    localparam logic [16:0] CHAL_NLEN_BASE  = 17'd36;
    localparam logic [16:0] CHAL_FLAGS_BASE = 17'd85;
    localparam logic [16:0] CHAL_LEN_BASE   = 17'd86;
    localparam logic [16:0] CHAL_FAIL_LEN   = 17'd3;
    localparam logic [16:0] CHAL_PIN_LEN    = 17'd20;
    localparam logic [16:0] CHAL_MATRIX_LEN = 17'd12;
    localparam logic [16:0] CHAL_TOKEN_LEN  = 17'd1;

    // realm list and proof layout
    localparam logic [16:0] REALM_HDR_LEN   = 17'd3;
    localparam logic [16:0] STATUS_OFF_ONE  = 17'd1;
    localparam logic [16:0] REALM_SIZE_HI   = 17'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_first;
        logic        frame_last;
        logic [1:0]  frame_kind;
        logic [16:0] byte_offset;
        logic        halted;
        logic        discarded;
    } result_t;

endpackage

### rtl/afld_in_stage.sv
`timescale 1ns / 1ps

module afld_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  afld_pkg::item_t in_item,
    output logic           item_valid,
    input  logic           item_take,
    output afld_pkg::item_t item
);
    import afld_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // stage may load when empty or when its request moves on this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/afld_framer.sv
`timescale 1ns / 1ps

module afld_framer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [5:0]        cfg_wdata,
    input  logic              step,
    input  afld_pkg::item_t   item,
    output afld_pkg::result_t result
);
    import afld_pkg::*;

    logic [5:0]  success_len_reg;
    logic [2:0]  failure_len_reg;

    logic        in_frame_reg,      in_frame_next;
    logic        halt_reg,          halt_next;
    logic [1:0]  kind_reg,          kind_next;
    logic [16:0] count_reg,         count_next;
    logic [16:0] frame_len_reg,     frame_len_next;
    logic        success_reg,       success_next;
    logic [7:0]  gen_len_reg,       gen_len_next;
    logic [7:0]  mod_len_reg,       mod_len_next;

    logic        opcode_ok;
    logic        last;
    logic [5:0]  proof_len;
    logic [16:0] chal_len;
    logic [16:0] off;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            success_len_reg <= PROOF_SUCCESS_LEN_RST;
            failure_len_reg <= PROOF_FAILURE_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PROOF_SUCCESS_LEN: success_len_reg <= cfg_wdata;
                CFG_PROOF_FAILURE_LEN: failure_len_reg <= cfg_wdata[2:0];
                default:               success_len_reg <= success_len_reg;
            endcase
        end
    end

    // per-byte framing decision
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        halt_next      = halt_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        frame_len_next = frame_len_reg;
        success_next   = success_reg;
        gen_len_next   = gen_len_reg;
        mod_len_next   = mod_len_reg;
        opcode_ok      = 1'b1;
        last           = 1'b0;
        proof_len      = '0;
        chal_len       = '0;
        off            = '0;
        result         = '0;

        if (item.req_type)
        begin
            // connection drop clears all framing state, halt included
            result.discarded = in_frame_reg;
            halt_next        = 1'b0;
            in_frame_next    = 1'b0;
            kind_next        = KIND_CHALLENGE;
            count_next       = '0;
            frame_len_next   = '0;
            success_next     = 1'b0;
            gen_len_next     = '0;
            mod_len_next     = '0;
        end
        else
        begin
            result.data_byte = item.in_byte;
            if (halt_reg)
            begin
                result.halted = 1'b1;
            end
            else
            begin
                // opcode decode at frame start
                if (!in_frame_reg)
                begin
                    case (item.in_byte)
                        OP_CHALLENGE: kind_next = KIND_CHALLENGE;
                        OP_PROOF:     kind_next = KIND_PROOF;
                        OP_REALM:     kind_next = KIND_REALM;
                        default:      opcode_ok = 1'b0;
                    endcase
                    if (opcode_ok)
                    begin
                        in_frame_next  = 1'b1;
                        count_next     = '0;
                        frame_len_next = '0;
                        success_next   = 1'b0;
                        gen_len_next   = '0;
                        mod_len_next   = '0;
                        result.frame_first = 1'b1;
                    end
                    else
                    begin
                        halt_next     = 1'b1;
                        result.halted = 1'b1;
                    end
                end

                if (opcode_ok)
                begin
                    off = count_next;
                    // length decision by kind
                    case (kind_next)
                        KIND_CHALLENGE:
                        begin
                            if (off == CHAL_STATUS_OFF)
                            begin
                                if (item.in_byte != 8'd0)
                                begin
                                    frame_len_next = CHAL_FAIL_LEN;
                                end
                                else
                                begin
                                    success_next = 1'b1;
                                end
                            end
                            else if (success_next)
                            begin
                                chal_len = CHAL_LEN_BASE + 17'(gen_len_next)
                                         + 17'(mod_len_next);
                                if (item.in_byte[0]) chal_len = chal_len + CHAL_PIN_LEN;
                                if (item.in_byte[1]) chal_len = chal_len + CHAL_MATRIX_LEN;
                                if (item.in_byte[2]) chal_len = chal_len + CHAL_TOKEN_LEN;
                                if (off == CHAL_GLEN_OFF)
                                begin
                                    gen_len_next = item.in_byte;
                                end
                                else if (off == CHAL_NLEN_BASE + 17'(gen_len_next))
                                begin
                                    mod_len_next = item.in_byte;
                                end
                                else if (off == CHAL_FLAGS_BASE + 17'(gen_len_next)
                                                + 17'(mod_len_next))
                                begin
                                    frame_len_next = chal_len;
                                end
                            end
                        end
                        KIND_PROOF:
                        begin
                            if (off == STATUS_OFF_ONE)
                            begin
                                proof_len = (item.in_byte == 8'd0) ? success_len_reg
                                                                   : 6'(failure_len_reg);
                                if (proof_len < PROOF_MIN_LEN)
                                begin
                                    proof_len = PROOF_MIN_LEN;
                                end
                                frame_len_next = 17'(proof_len);
                            end
                        end
                        default:
                        begin
                            // realm list: little-endian size at offsets 1 and 2
                            if (off == STATUS_OFF_ONE)
                            begin
                                gen_len_next = item.in_byte;
                            end
                            else if (off == REALM_SIZE_HI)
                            begin
                                frame_len_next = REALM_HDR_LEN
                                               + 17'({item.in_byte, gen_len_next});
                            end
                        end
                    endcase

                    last = (frame_len_next != 17'd0)
                        && (({1'b0, off} + 18'd1) == {1'b0, frame_len_next});

                    result.frame_last  = last;
                    result.frame_kind  = kind_next;
                    result.byte_offset = off;

                    if (last)
                    begin
                        in_frame_next  = 1'b0;
                        kind_next      = KIND_CHALLENGE;
                        count_next     = '0;
                        frame_len_next = '0;
                        success_next   = 1'b0;
                        gen_len_next   = '0;
                        mod_len_next   = '0;
                    end
                    else
                    begin
                        count_next = off + 17'd1;
                    end
                end
            end
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            halt_reg      <= 1'b0;
            kind_reg      <= KIND_CHALLENGE;
            count_reg     <= '0;
            frame_len_reg <= '0;
            success_reg   <= 1'b0;
            gen_len_reg   <= '0;
            mod_len_reg   <= '0;
        end
        else if (step)
        begin
            in_frame_reg  <= in_frame_next;
            halt_reg      <= halt_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            frame_len_reg <= frame_len_next;
            success_reg   <= success_next;
            gen_len_reg   <= gen_len_next;
            mod_len_reg   <= mod_len_next;
        end
    end

endmodule

### rtl/afld_out_stage.sv
`timescale 1ns / 1ps

module afld_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  afld_pkg::result_t res_in,
    output logic              out_valid,
    input  logic              out_ready,
    output afld_pkg::result_t res_out
);
    import afld_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // loads when empty or when the held request leaves this cycle
    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

### rtl/auth_frame_length_deframer_top.sv
// Login-protocol frame deframer.
// The slave channel takes one request per accepted cycle: s_tuser says whether it is a
// received byte (0) or a connection drop (1), s_tdata carries the byte. For every request
// exactly one result leaves on the master channel: the byte, its offset within the
// frame, the frame kind, first/last marks (last on m_tlast), and halt/discard flags.
// Frame length is decided from the opcode and from length fields inside the frame.
// An unknown opcode halts framing until a drop; a drop clears all framing state.
// Throughput is one request per cycle while m_tready stays high. An accepted request
// waits in the input register while the framing logic works on it, and its result is
// then loaded into the result register, which raises m_tvalid.
// The framing counter and length are updated once per request, so the per-byte
// decision is the only loop and is computed combinationally from the framing state.
// When the receiver stalls, the result register holds and the input register keeps
// accepting until it too is full; then s_tready drops. Nothing is lost or repeated.
// Reset clears both registers and all framing state and loads the proof lengths to
// 32 (success) and 2 (failure). cfg_we writes register cfg_addr with cfg_wdata
// (0 success, 1 failure length); users write only while the block is idle (unchecked).
`timescale 1ns / 1ps

module auth_frame_length_deframer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [24:8] byte_offset, [31:25] zero
    output logic        m_tlast,   // frame_last
    output logic [4:0]  m_tuser    // [0] frame_first, [2:1] frame_kind, [3] halted,
                                   // [4] discarded
);
    import afld_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    res_ready;
    result_t res;
    result_t res_out;

    assign in_item.req_type = s_tuser;
    assign in_item.in_byte  = s_tdata;

    // input register
    afld_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (res_ready),
        .item       (item)
    );

    // framing state and per-byte decision
    afld_framer u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (item_valid && res_ready),
        .item      (item),
        .result    (res)
    );

    // result register
    afld_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res_in    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_out)
    );

    // pack the result
    assign m_tdata = {7'd0, res_out.byte_offset, res_out.data_byte};
    assign m_tlast = res_out.frame_last;
    assign m_tuser = {res_out.discarded, res_out.halted, res_out.frame_kind,
                      res_out.frame_first};

`ifndef SYNTH
    // an opcode byte can never close its own frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tlast)
        else $error("frame first and last on the same byte");

    // a halted or dropped request carries no framing marks
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3] || m_tuser[4]) |-> !m_tlast && !m_tuser[0]
        && (m_tdata[24:8] == 17'd0) && (m_tuser[2:1] == KIND_CHALLENGE))
        else $error("framing marks on an unframed result");

    // kind code stays within the three frame kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:1] != 2'b11)
        else $error("invalid frame kind");

    // a drop result is all zero apart from the discard flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> (m_tdata == 32'd0) && !m_tuser[3])
        else $error("drop result carries data");
`endif

endmodule

### tb/tb_auth_frame_length_deframer_top.sv
`timescale 1ns / 1ps

module tb_auth_frame_length_deframer_top;

    import afld_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int unsigned IDLE_SETTLE  = 6;
    localparam int unsigned REPORT_LIMIT = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [4:0]  m_tuser;

    auth_frame_length_deframer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // requests waiting to be driven, marks waiting to come out
    item_t       pending_reqs[$];
    item_t       frame_buf[$];
    result_t     expected_marks[$];

    logic        req_taken;
    int unsigned send_gap;
    int unsigned stall_left;
    bit          no_idle;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // framer model state and its copy of the proof lengths
    logic [5:0]  cfg_succ_len;
    logic [2:0]  cfg_fail_len;
    logic        fr_active;
    logic        fr_halted;
    logic [1:0]  fr_kind;
    logic [16:0] fr_count;
    logic [16:0] fr_len;
    logic        fr_success;
    logic [7:0]  fr_glen;
    logic [7:0]  fr_nlen;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic drop_frame_state();
        fr_active  = 1'b0;
        fr_kind    = KIND_CHALLENGE;
        fr_count   = '0;
        fr_len     = '0;
        fr_success = 1'b0;
        fr_glen    = '0;
        fr_nlen    = '0;
    endtask

    // expected boundary marks for one request, advances the model state
    task automatic predict_frame_mark(input item_t req, output result_t mark);
        logic [16:0] off;
        logic [16:0] len;
        logic [7:0]  b;
        b    = req.in_byte;
        mark = '0;
        if (req.req_type)
        begin
            mark.discarded = fr_active;
            fr_halted      = 1'b0;
            drop_frame_state();
            return;
        end
        mark.data_byte = b;
        if (fr_halted)
        begin
            mark.halted = 1'b1;
            return;
        end
        // opcode opens a frame or halts framing
        if (!fr_active)
        begin
            case (b)
                OP_CHALLENGE: fr_kind = KIND_CHALLENGE;
                OP_PROOF:     fr_kind = KIND_PROOF;
                OP_REALM:     fr_kind = KIND_REALM;
                default:
                begin
                    fr_halted   = 1'b1;
                    mark.halted = 1'b1;
                    return;
                end
            endcase
            fr_active        = 1'b1;
            fr_count         = '0;
            fr_len           = '0;
            fr_success       = 1'b0;
            fr_glen          = '0;
            fr_nlen          = '0;
            mark.frame_first = 1'b1;
        end
        off = fr_count;
        // length decisions by kind
        if (fr_kind == KIND_CHALLENGE)
        begin
            if (off == CHAL_STATUS_OFF)
            begin
                if (b != 8'd0)
                    fr_len = CHAL_FAIL_LEN;
                else
                    fr_success = 1'b1;
            end
            else if (fr_success)
            begin
                if (off == CHAL_GLEN_OFF)
                    fr_glen = b;
                else if (off == CHAL_NLEN_BASE + 17'(fr_glen))
                    fr_nlen = b;
                else if (off == CHAL_FLAGS_BASE + 17'(fr_glen) + 17'(fr_nlen))
                begin
                    len = CHAL_LEN_BASE + 17'(fr_glen) + 17'(fr_nlen);
                    if (b[0])
                        len = len + CHAL_PIN_LEN;
                    if (b[1])
                        len = len + CHAL_MATRIX_LEN;
                    if (b[2])
                        len = len + CHAL_TOKEN_LEN;
                    fr_len = len;
                end
            end
        end
        else if (fr_kind == KIND_PROOF)
        begin
            if (off == STATUS_OFF_ONE)
            begin
                len = (b == 8'd0) ? 17'(cfg_succ_len) : 17'(cfg_fail_len);
                // status byte is always inside the frame
                if (len < 17'd2)
                    len = 17'd2;
                fr_len = len;
            end
        end
        else
        begin
            if (off == STATUS_OFF_ONE)
                fr_glen = b;
            else if (off == REALM_SIZE_HI)
                fr_len = REALM_HDR_LEN + 17'({b, fr_glen});
        end
        mark.frame_last  = (fr_len != '0) && (off + 17'd1 == fr_len);
        mark.frame_kind  = fr_kind;
        mark.byte_offset = off;
        if (mark.frame_last)
            drop_frame_state();
        else
            fr_count = fr_count + 17'd1;
    endtask

    // idle lengths: mostly short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_field_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 8));
        if (r < 90)
            return 8'($urandom_range(9, 40));
        return 8'($urandom_range(41, 255));
    endfunction

    function automatic logic [15:0] pick_realm_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 20));
        if (r < 95)
            return 16'($urandom_range(21, 200));
        return 16'($urandom_range(201, 700));
    endfunction

    task automatic send(input logic req, input logic [7:0] b);
        pending_reqs.insert(pending_reqs.size(), {req, b});
    endtask

    task automatic put_byte(input logic [7:0] b);
        frame_buf.insert(frame_buf.size(), {1'b0, b});
    endtask

    // one well-formed frame of the given kind into frame_buf
    task automatic build_frame(input logic [1:0] kind);
        logic [7:0]  st;
        logic [7:0]  g;
        logic [7:0]  n;
        logic [7:0]  flags;
        logic [15:0] size;
        int unsigned len;
        int unsigned fpos;
        frame_buf.delete();
        case (kind)
            KIND_CHALLENGE:
            begin
                put_byte(OP_CHALLENGE);
                put_byte(8'($urandom));
                if ($urandom_range(0, 99) < 40)
                begin
                    put_byte(8'($urandom_range(1, 255)));
                end
                else
                begin
                    put_byte(8'd0);
                    g    = pick_field_len();
                    n    = pick_field_len();
                    fpos = 85 + int'(g) + int'(n);
                    for (int unsigned off = 3; off < fpos; off++)
                    begin
                        if (off == 35)
                            put_byte(g);
                        else if (off == 36 + int'(g))
                            put_byte(n);
                        else
                            put_byte(8'($urandom));
                    end
                    flags = 8'($urandom);
                    put_byte(flags);
                    len = fpos + 1 + (flags[0] ? 20 : 0) + (flags[1] ? 12 : 0)
                          + (flags[2] ? 1 : 0);
                    while (frame_buf.size() < len)
                        put_byte(8'($urandom));
                end
            end
            KIND_PROOF:
            begin
                st = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                put_byte(OP_PROOF);
                put_byte(st);
                len = (st == 8'd0) ? int'(cfg_succ_len) : int'(cfg_fail_len);
                if (len < 2)
                    len = 2;
                while (frame_buf.size() < len)
                    put_byte(8'($urandom));
            end
            default:
            begin
                size = pick_realm_size();
                put_byte(OP_REALM);
                put_byte(size[7:0]);
                put_byte(size[15:8]);
                len = 3 + int'(size);
                while (frame_buf.size() < len)
                    put_byte(8'($urandom));
            end
        endcase
    endtask

    // mostly whole frames, the rest cut frames, drops and bad opcodes
    task automatic gen_traffic(input int unsigned n_items);
        int unsigned added;
        int unsigned sel;
        int unsigned cut;
        logic [7:0]  bad;
        added = 0;
        while (added < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 88)
            begin
                build_frame(2'($urandom_range(0, 2)));
                if (sel >= 78)
                begin
                    cut = $urandom_range(1, frame_buf.size() - 1);
                    while (frame_buf.size() > cut)
                        void'(frame_buf.pop_back());
                    frame_buf.insert(frame_buf.size(), {1'b1, 8'($urandom)});
                end
            end
            else if (sel < 93)
            begin
                frame_buf.delete();
                frame_buf.insert(frame_buf.size(), {1'b1, 8'($urandom)});
            end
            else
            begin
                frame_buf.delete();
                bad = 8'($urandom);
                while (bad == OP_CHALLENGE || bad == OP_PROOF || bad == OP_REALM)
                    bad = 8'($urandom);
                put_byte(bad);
                repeat ($urandom_range(0, 5))
                    put_byte(8'($urandom));
                frame_buf.insert(frame_buf.size(), {1'b1, 8'($urandom)});
            end
            added += frame_buf.size();
            foreach (frame_buf[i])
                pending_reqs.insert(pending_reqs.size(), frame_buf[i]);
        end
    endtask

    task automatic write_reg(input logic addr, input logic [5:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == CFG_PROOF_SUCCESS_LEN)
            cfg_succ_len = value;
        else
            cfg_fail_len = value[2:0];
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_marks.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin : driver
        item_t pending_item;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                pending_item = pending_reqs.pop_front();
                s_tvalid     <= 1'b1;
                s_tuser      <= pending_item.req_type;
                s_tdata      <= pending_item.in_byte;
                send_gap     <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap();
        end
    end

    // check results, then predict for the accepted request
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.data_byte   = m_tdata[7:0];
                got.byte_offset = m_tdata[24:8];
                got.frame_last  = m_tlast;
                got.frame_first = m_tuser[0];
                got.frame_kind  = m_tuser[2:1];
                got.halted      = m_tuser[3];
                got.discarded   = m_tuser[4];
                if (expected_marks.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result: byte=%h off=%0d", got.data_byte,
                                 got.byte_offset);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $display("mismatch: exp byte=%h first=%b last=%b kind=%0d off=%0d halt=%b disc=%b",
                                     want.data_byte, want.frame_first, want.frame_last,
                                     want.frame_kind, want.byte_offset, want.halted,
                                     want.discarded);
                            $display("          got byte=%h first=%b last=%b kind=%0d off=%0d halt=%b disc=%b",
                                     got.data_byte, got.frame_first, got.frame_last,
                                     got.frame_kind, got.byte_offset, got.halted,
                                     got.discarded);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_frame_mark({s_tuser, s_tdata}, want);
                expected_marks.insert(expected_marks.size(), want);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // reset, directed requests, then random phases over several settings
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_PROOF_SUCCESS_LEN;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        req_taken      = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        cfg_succ_len   = PROOF_SUCCESS_LEN_RST;
        cfg_fail_len   = PROOF_FAILURE_LEN_RST;
        fr_halted      = 1'b0;
        drop_frame_state();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drop with nothing in flight
        send(1'b1, 8'hFF);
        // challenge with failure status
        send(1'b0, OP_CHALLENGE);
        send(1'b0, 8'h5A);
        send(1'b0, 8'hFF);
        // failed proof at reset length
        send(1'b0, OP_PROOF);
        send(1'b0, 8'h80);
        // empty realm list, then one with a single byte
        send(1'b0, OP_REALM);
        send(1'b0, 8'h00);
        send(1'b0, 8'h00);
        send(1'b0, OP_REALM);
        send(1'b0, 8'h01);
        send(1'b0, 8'h00);
        send(1'b0, 8'hAA);
        // partial proof thrown away
        send(1'b0, OP_PROOF);
        send(1'b0, 8'h00);
        send(1'b0, 8'h55);
        send(1'b1, 8'h00);
        // largest realm size, cut short
        send(1'b0, OP_REALM);
        send(1'b0, 8'hFF);
        send(1'b0, 8'hFF);
        send(1'b0, 8'h00);
        send(1'b1, 8'h00);
        // unknown opcode halts, bytes pass through until the drop
        send(1'b0, 8'h02);
        send(1'b0, 8'h00);
        send(1'b0, OP_REALM);
        send(1'b1, 8'hFF);
        gen_traffic(180);
        wait_idle();

        for (int p = 1; p <= 5; p++)
        begin
            case (p)
                1:
                begin
                    write_reg(CFG_PROOF_SUCCESS_LEN, 6'd26);
                    write_reg(CFG_PROOF_FAILURE_LEN, {3'($urandom), 3'd4});
                end
                2:
                begin
                    write_reg(CFG_PROOF_SUCCESS_LEN, 6'd0);
                    write_reg(CFG_PROOF_FAILURE_LEN, {3'($urandom), 3'd0});
                end
                3:
                begin
                    write_reg(CFG_PROOF_SUCCESS_LEN, 6'd63);
                    write_reg(CFG_PROOF_FAILURE_LEN, {3'($urandom), 3'd7});
                end
                4:
                begin
                    write_reg(CFG_PROOF_SUCCESS_LEN, 6'd1);
                    write_reg(CFG_PROOF_FAILURE_LEN, {3'($urandom), 3'd1});
                end
                default:
                begin
                    write_reg(CFG_PROOF_SUCCESS_LEN, 6'($urandom_range(26, 32)));
                    write_reg(CFG_PROOF_FAILURE_LEN,
                              {3'($urandom), 3'($urandom_range(2, 4))});
                end
            endcase
            no_idle = (p == 1);
            gen_traffic(170);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_marks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
